### hdl/poi_pkg.sv
// package: constants, types and tables for the planar odometry integrator
package poi_pkg;

    localparam int CordicSteps = 16;
    localparam int AngTableLen = 24;
    localparam int CordicIters = (CordicSteps < AngTableLen) ? CordicSteps : AngTableLen;
    localparam int IterW = $clog2(AngTableLen + 1);

    localparam logic signed [33:0] CordicGainInit = 34'sd652032874;
    localparam logic signed [33:0] UnitQ30 = 34'sd1073741824;
    localparam logic [29:0] RadToBamQ16 = 30'd683565276;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MVX,
        ST_MVY,
        ST_MWZ,
        ST_MHK,
        ST_HUPD,
        ST_COR1,
        ST_MAC,
        ST_MBS,
        ST_MAS,
        ST_MBC,
        ST_SUMY,
        ST_DY,
        ST_ACC,
        ST_COR2
    } state_t;

    typedef enum logic [2:0] {
        MUL_VXDT,
        MUL_VYDT,
        MUL_WZDT,
        MUL_WK,
        MUL_AC,
        MUL_BS,
        MUL_AS,
        MUL_BC
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     cor_start;
        logic     cor_half;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     a_take;
        logic     b_take;
        logic     h_take;
        logic     sc_take;
        logic     sum_load;
        logic     sum_add;
        logic     sum_sub;
        logic     dx_take;
        logic     dy_take;
        logic     acc_en;
        logic     out_take;
    } ctrl_t;

    typedef struct packed {
        logic cor_busy;
    } stat_t;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'd536870912;
            5'd1: r = 32'd316933406;
            5'd2: r = 32'd167458907;
            5'd3: r = 32'd85004756;
            5'd4: r = 32'd42667331;
            5'd5: r = 32'd21354465;
            5'd6: r = 32'd10679838;
            5'd7: r = 32'd5340245;
            5'd8: r = 32'd2670163;
            5'd9: r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

### hdl/poi_if.sv
// valid/ready channel interfaces for velocity samples and poses
interface poi_in_if (input logic clk);
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] yaw_rate;
    logic        [15:0] elapsed_time;
    modport source (output valid, vel_x, vel_y, yaw_rate, elapsed_time, input ready);
    modport sink (input valid, vel_x, vel_y, yaw_rate, elapsed_time, output ready);
endinterface

interface poi_out_if (input logic clk);
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading_out;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    modport source (output valid, pos_x, pos_y, heading_out, quat_z, quat_w, input ready);
    modport sink (input valid, pos_x, pos_y, heading_out, quat_z, quat_w, output ready);
endinterface

### hdl/poi_cordic.sv
// iterative rotation-mode cordic, one micro-rotation per cycle
module poi_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               busy,
    output logic signed [33:0] sin_out,
    output logic signed [33:0] cos_out
);
    import poi_pkg::*;

    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic [IterW-1:0]   it_reg, it_next;
    logic               busy_reg, busy_next;
    logic signed [33:0] za, xs, ys, xf, yf;
    logic signed [33:0] at;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        flip_next = flip_reg;
        it_next = it_reg;
        busy_next = busy_reg;
        za = 34'(signed'(angle));
        xs = x_reg >>> it_reg;
        ys = y_reg >>> it_reg;
        at = 34'(atan_turns(5'(it_reg)));
        if (start)
        begin
            // fold into +-90 degrees and negate at the end
            if (za > 34'sd1073741824)
            begin
                z_next = za - 34'sd2147483648;
                flip_next = 1'b1;
            end
            else if (za < -34'sd1073741824)
            begin
                z_next = za + 34'sd2147483648;
                flip_next = 1'b1;
            end
            else
            begin
                z_next = za;
                flip_next = 1'b0;
            end
            x_next = CordicGainInit;
            y_next = '0;
            it_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!z_reg[33])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IterW'(CordicIters - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            it_reg <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        flip_reg <= flip_next;
    end

    always_comb
    begin
        xf = flip_reg ? -x_reg : x_reg;
        yf = flip_reg ? -y_reg : y_reg;
        cos_out = (xf > UnitQ30) ? UnitQ30 : ((xf < -UnitQ30) ? -UnitQ30 : xf);
        sin_out = (yf > UnitQ30) ? UnitQ30 : ((yf < -UnitQ30) ? -UnitQ30 : yf);
    end

    assign busy = busy_reg;

`ifndef SYNTH
    a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> it_reg < IterW'(CordicIters))
        else $error("cordic iteration out of range");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && it_reg == '0)
        else $error("cordic did not start");
    a_ends: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && it_reg == IterW'(CordicIters - 1) |=> !busy_reg)
        else $error("cordic did not end");
`endif
endmodule

### hdl/poi_datapath.sv
// datapath: sample registers, shared multiplier, accumulators and result
module poi_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  poi_pkg::ctrl_t      ctrl,
    output poi_pkg::stat_t      stat,
    input  logic signed [15:0]  in_vx,
    input  logic signed [15:0]  in_vy,
    input  logic signed [15:0]  in_wz,
    input  logic        [15:0]  in_dt,
    output logic signed [31:0]  o_x,
    output logic signed [31:0]  o_y,
    output logic        [15:0]  o_h,
    output logic signed [15:0]  o_qz,
    output logic signed [15:0]  o_qw
);
    import poi_pkg::*;

    logic signed [15:0] vx_reg, vy_reg, wz_reg;
    logic        [15:0] dt_reg;
    logic signed [31:0] a_reg, b_reg;     // velocity times interval
    logic signed [31:0] s_reg, c_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] sum_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic signed [31:0] xa_reg, ya_reg;
    logic        [15:0] h_reg;
    logic signed [31:0] xo_reg, yo_reg;
    logic        [15:0] ho_reg;
    logic signed [15:0] qz_reg, qw_reg;

    logic               cor_busy;
    logic signed [33:0] cs, cc;
    logic [31:0]        cor_angle;

    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic signed [63:0] mp;
    logic signed [63:0] rnd;
    logic signed [32:0] sx, sy;
    logic [15:0]        hn;
    logic signed [33:0] qzr, qwr;

    assign cor_angle = ctrl.cor_half ? {1'b0, h_reg, 15'd0} : {h_reg, 16'd0};

    poi_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctrl.cor_start),
        .angle   (cor_angle),
        .busy    (cor_busy),
        .sin_out (cs),
        .cos_out (cc)
    );

    assign stat.cor_busy = cor_busy;

    // operand select for the shared multiplier
    always_comb
    begin
        case (ctrl.mul_sel)
            MUL_VXDT: begin ma = 32'(vx_reg); mb = signed'({16'd0, dt_reg}); end
            MUL_VYDT: begin ma = 32'(vy_reg); mb = signed'({16'd0, dt_reg}); end
            MUL_WZDT: begin ma = 32'(wz_reg); mb = signed'({16'd0, dt_reg}); end
            MUL_WK:   begin ma = signed'(prod_reg[31:0]); mb = signed'({2'b00, RadToBamQ16}); end
            MUL_AC:   begin ma = a_reg; mb = c_reg; end
            MUL_BS:   begin ma = b_reg; mb = s_reg; end
            MUL_AS:   begin ma = a_reg; mb = s_reg; end
            MUL_BC:   begin ma = b_reg; mb = c_reg; end
            default:  begin ma = '0; mb = '0; end
        endcase
        mp = 64'(ma) * 64'(mb);
    end

    always_comb
    begin
        rnd = sum_reg + (64'sd1 <<< 37);
        sx = 33'(xa_reg) + 33'(dx_reg);
        sy = 33'(ya_reg) + 33'(dy_reg);
        hn = h_reg + 16'((prod_reg + (64'sd1 <<< 43)) >>> 44);
        qzr = (cs + 34'sd32768) >>> 16;
        qwr = (cc + 34'sd32768) >>> 16;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xa_reg <= '0;
            ya_reg <= '0;
            h_reg <= '0;
        end
        else
        begin
            if (ctrl.h_take)
                h_reg <= hn;
            if (ctrl.acc_en)
            begin
                xa_reg <= (sx > 33'sd2147483647) ? 32'sh7fffffff :
                          (sx < -33'sd2147483648) ? 32'sh80000000 : 32'(sx);
                ya_reg <= (sy > 33'sd2147483647) ? 32'sh7fffffff :
                          (sy < -33'sd2147483648) ? 32'sh80000000 : 32'(sy);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            vx_reg <= in_vx;
            vy_reg <= in_vy;
            wz_reg <= in_wz;
            dt_reg <= in_dt;
        end
        if (ctrl.a_take)
            a_reg <= prod_reg[31:0];
        if (ctrl.b_take)
            b_reg <= prod_reg[31:0];
        // sine and cosine are clamped to +-1.0 so they fit in 32 bits
        if (ctrl.sc_take)
        begin
            s_reg <= 32'(cs);
            c_reg <= 32'(cc);
        end
        if (ctrl.mul_en)
            prod_reg <= mp;
        if (ctrl.sum_load)
            sum_reg <= prod_reg;
        else if (ctrl.sum_add)
            sum_reg <= sum_reg + prod_reg;
        else if (ctrl.sum_sub)
            sum_reg <= sum_reg - prod_reg;
        if (ctrl.dx_take)
            dx_reg <= 32'(rnd >>> 38);
        if (ctrl.dy_take)
            dy_reg <= 32'(rnd >>> 38);
        if (ctrl.out_take)
        begin
            xo_reg <= xa_reg;
            yo_reg <= ya_reg;
            ho_reg <= h_reg;
            qz_reg <= (qzr > 34'sd16384) ? 16'sd16384 :
                      (qzr < -34'sd16384) ? -16'sd16384 : 16'(qzr);
            qw_reg <= (qwr > 34'sd16384) ? 16'sd16384 :
                      (qwr < -34'sd16384) ? -16'sd16384 : 16'(qwr);
        end
    end

    assign o_x = xo_reg;
    assign o_y = yo_reg;
    assign o_h = ho_reg;
    assign o_qz = qz_reg;
    assign o_qw = qw_reg;
endmodule

### hdl/poi_ctrl.sv
// controller state machine sequencing cordic, multiplies and accumulate
module poi_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  poi_pkg::stat_t stat,
    output poi_pkg::ctrl_t ctrl
);
    import poi_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_MVX;
            ST_MVX:  state_next = ST_MVY;
            ST_MVY:  state_next = ST_MWZ;
            ST_MWZ:  state_next = ST_MHK;
            ST_MHK:  state_next = ST_HUPD;
            ST_HUPD: state_next = ST_COR1;
            ST_COR1: if (!stat.cor_busy) state_next = ST_MAC;
            ST_MAC:  state_next = ST_MBS;
            ST_MBS:  state_next = ST_MAS;
            ST_MAS:  state_next = ST_MBC;
            ST_MBC:  state_next = ST_SUMY;
            ST_SUMY: state_next = ST_DY;
            ST_DY:   state_next = ST_ACC;
            ST_ACC:  state_next = ST_COR2;
            ST_COR2: if (!stat.cor_busy && (!ov_reg || out_ready)) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        if (ctrl.out_take)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        ctrl = '0;
        ctrl.mul_sel = MUL_VXDT;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    ctrl.load = 1'b1;
                    ctrl.cor_start = 1'b1;
                end
            // interval products and heading step overlap the first cordic pass
            ST_MVX:  begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_VXDT; end
            ST_MVY:  begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_VYDT; ctrl.a_take = 1'b1; end
            ST_MWZ:  begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_WZDT; ctrl.b_take = 1'b1; end
            ST_MHK:  begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_WK; end
            ST_HUPD: ctrl.h_take = 1'b1;
            ST_COR1:
                if (!stat.cor_busy)
                begin
                    ctrl.sc_take = 1'b1;
                    ctrl.cor_start = 1'b1;
                    ctrl.cor_half = 1'b1;
                end
            ST_MAC:  begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_AC; end
            ST_MBS:  begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_BS; ctrl.sum_load = 1'b1; end
            ST_MAS:  begin ctrl.mul_en = 1'b1; ctrl.mul_sel = MUL_AS; ctrl.sum_sub = 1'b1; end
            ST_MBC:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.mul_sel = MUL_BC;
                ctrl.dx_take = 1'b1;
                ctrl.sum_load = 1'b1;
            end
            ST_SUMY: ctrl.sum_add = 1'b1;
            ST_DY:   ctrl.dy_take = 1'b1;
            ST_ACC:  ctrl.acc_en = 1'b1;
            ST_COR2: if (!stat.cor_busy && (!ov_reg || out_ready)) ctrl.out_take = 1'b1;
            default: ;
        endcase
    end

`ifndef SYNTH
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg)
        else $error("pending result dropped");
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_take |-> !ov_reg || out_ready)
        else $error("result register overwritten");
    a_acc_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACC |=> state_reg == ST_COR2)
        else $error("accumulate step out of order");
    a_second_pass: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COR1 && !stat.cor_busy |-> ctrl.cor_start && ctrl.cor_half)
        else $error("quaternion pass not started");
`endif
endmodule

### hdl/planar_odometry_integrator.sv
// top level: planar odometry integrator
// a new sample is taken only in idle, after the previous result is in the output register;
// the pace is set by the two passes through the single iterative cordic; the multiplies
// run alongside the passes
// a result waiting in the output register only holds the next sample at its last step
// reset clears position, heading and all control state
module planar_odometry_integrator (
    input logic     clk,
    input logic     rst_n,
    poi_in_if.sink  in_ch,
    poi_out_if.source out_ch
);
    import poi_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    poi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    poi_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .in_vx (in_ch.vel_x),
        .in_vy (in_ch.vel_y),
        .in_wz (in_ch.yaw_rate),
        .in_dt (in_ch.elapsed_time),
        .o_x   (out_ch.pos_x),
        .o_y   (out_ch.pos_y),
        .o_h   (out_ch.heading_out),
        .o_qz  (out_ch.quat_z),
        .o_qw  (out_ch.quat_w)
    );
endmodule

### tb/sv/planar_odometry_integrator_tb.sv
`timescale 1ns / 1ps
// testbench for the planar odometry integrator: random samples, pose prediction and checking
module planar_odometry_integrator_tb;
    import poi_pkg::*;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] yaw_rate;
        logic        [15:0] elapsed_time;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading_out;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } pose_t;

    localparam longint Unit = 64'sd1073741824;

    logic clk;
    logic rst_n;

    poi_in_if  in_ch (clk);
    poi_out_if out_ch (clk);

    planar_odometry_integrator u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    sample_t pending_samples[$];
    pose_t   expected_poses[$];
    int      mismatches;
    int      accepted_samples;
    int      sent_samples;
    bit      stim_done;
    int      hold_off;
    int      send_gap;
    int      recv_gap;

    // predicted pose state
    longint  px;
    longint  py;
    logic [15:0] hdg;

    function automatic longint floor_shr(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint round_shr(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // rotation-mode cordic, angle in 2^-32 turn, results in Q2.30
    task automatic sin_cos(input logic [31:0] angle, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        bit     flip;
        z = longint'(angle);
        x = 64'sd652032874;
        y = 0;
        flip = 0;
        if (z >= 64'sd2147483648)
            z -= 64'sd4294967296;
        if (z > Unit)
        begin
            z -= 64'sd2147483648;
            flip = 1;
        end
        else if (z < -Unit)
        begin
            z += 64'sd2147483648;
            flip = 1;
        end
        for (int i = 0; i < CordicIters; i++)
        begin
            if (z >= 0)
            begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= longint'(atan_turns(i[4:0]));
            end
            else
            begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += longint'(atan_turns(i[4:0]));
            end
            x = nx;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        s = clip(y, -Unit, Unit);
        c = clip(x, -Unit, Unit);
    endtask

    task automatic integrate_sample(input sample_t smp);
        longint vx, vy, wz, dt, s, c, dh;
        pose_t  p;
        vx = longint'(smp.vel_x);
        vy = longint'(smp.vel_y);
        wz = longint'(smp.yaw_rate);
        dt = longint'({1'b0, smp.elapsed_time});
        sin_cos({hdg, 16'd0}, s, c);
        px = clip(px + round_shr((vx * c - vy * s) * dt, 38), -64'sd2147483648, 64'sd2147483647);
        py = clip(py + round_shr((vx * s + vy * c) * dt, 38), -64'sd2147483648, 64'sd2147483647);
        dh = round_shr(wz * dt * 64'sd683565276, 44);
        hdg = hdg + dh[15:0];
        sin_cos({1'b0, hdg, 15'd0}, s, c);
        p.pos_x = px[31:0];
        p.pos_y = py[31:0];
        p.heading_out = hdg;
        p.quat_z = 16'(clip(round_shr(s, 16), -16384, 16384));
        p.quat_w = 16'(clip(round_shr(c, 16), -16384, 16384));
        expected_poses.push_back(p);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic sample_t random_sample();
        sample_t smp;
        int      r;
        smp = sample_t'({$urandom, $urandom});
        r = $urandom_range(0, 9);
        // mostly modest motion so the pose wanders without sitting at the rails
        if (r < 6)
        begin
            smp.vel_x = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            smp.vel_y = $signed(16'($urandom_range(0, 511))) - 16'sd256;
        end
        if (r == 9)
            smp.elapsed_time = $urandom_range(0, 3) == 0 ? 16'd0 : 16'hffff;
        return smp;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.vel_x = 0;
        in_ch.vel_y = 0;
        in_ch.yaw_rate = 0;
        in_ch.elapsed_time = 0;
        out_ch.ready = 0;
        mismatches = 0;
        accepted_samples = 0;
        sent_samples = 0;
        stim_done = 0;
        hold_off = 0;
        send_gap = 0;
        recv_gap = 0;
        px = 0;
        py = 0;
        hdg = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, zero interval, heading wrap, saturation
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd0, 16'd0});
        pending_samples.push_back('{16'sd256, 16'sd0, 16'sd0, 16'hffff});
        pending_samples.push_back('{16'sd0, 16'sd256, 16'sd0, 16'hffff});
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'hffff});
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'hffff});
        pending_samples.push_back('{16'sd0, 16'sd0, -16'sd32768, 16'hffff});
        pending_samples.push_back('{16'sd0, 16'sd0, 16'sd6434, 16'h8000});
        pending_samples.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, 16'hffff});
        pending_samples.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'd0});
        pending_samples.push_back('{16'sd32767, 16'sd32767, 16'sd12, 16'h0001});
        for (int i = 0; i < 8; i++)
            pending_samples.push_back('{16'sd32767, -16'sd32768, 16'sd0, 16'hffff});
        for (int i = 0; i < 6; i++)
            pending_samples.push_back('{-16'sd32768, 16'sd32767, 16'sd9000, 16'hffff});
        for (int i = 0; i < 1625; i++)
            pending_samples.push_back(random_sample());
        stim_done = 1;
    end

    // driver: the item on the bus is done once the monitor has counted its transfer
    always @(negedge clk)
    begin
        sample_t smp;
        if (rst_n)
        begin
            if (in_ch.valid && accepted_samples == sent_samples)
                send_gap = pick_gap();
            if (!in_ch.valid || accepted_samples == sent_samples)
            begin
                if (send_gap == 0 && pending_samples.size() > 0)
                begin
                    smp = pending_samples.pop_front();
                    in_ch.vel_x <= smp.vel_x;
                    in_ch.vel_y <= smp.vel_y;
                    in_ch.yaw_rate <= smp.yaw_rate;
                    in_ch.elapsed_time <= smp.elapsed_time;
                    in_ch.valid <= 1;
                    sent_samples++;
                end
                else
                begin
                    if (send_gap > 0)
                        send_gap--;
                    in_ch.valid <= 0;
                end
            end
        end
    end

    // receiver: one long hold-off early on, otherwise random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (accepted_samples == 40 && hold_off == 0)
                hold_off = 300;
            if (hold_off > 1)
            begin
                hold_off--;
                out_ch.ready <= 0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 0;
            end
            else
            begin
                out_ch.ready <= 1;
                if ($urandom_range(0, 9) == 0)
                    recv_gap = pick_gap();
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        sample_t seen;
        pose_t   got;
        pose_t   want;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            seen = '{in_ch.vel_x, in_ch.vel_y, in_ch.yaw_rate, in_ch.elapsed_time};
            integrate_sample(seen);
            accepted_samples++;
        end
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.pos_x, out_ch.pos_y, out_ch.heading_out, out_ch.quat_z, out_ch.quat_w};
            if (expected_poses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pose transfer %p", got);
            end
            else
            begin
                want = expected_poses.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pose mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial
    begin
        wait (stim_done && pending_samples.size() == 0 && !in_ch.valid);
        wait (expected_poses.size() == 0);
        repeat (2 * CordicIters + 40) @(posedge clk);
        if (mismatches == 0 && expected_poses.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
